// File: src/qmix_pkg.sv
// ============================================================================
// qmix_pkg: shared types and constants of the quad mixer
// Holds the controller/datapath command and status structs, the field widths
// of the stream beats and the fixed levels of the mixer.
// ============================================================================
package qmix_pkg;

  // Stream beat widths
  localparam int InDataW  = 64;
  localparam int OutDataW = 40;

  // Request kinds carried in tuser of the input beat
  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  // Motor index order used for the level registers
  localparam logic [1:0] MOT_FR = 2'd0;
  localparam logic [1:0] MOT_FL = 2'd1;
  localparam logic [1:0] MOT_RR = 2'd2;
  localparam logic [1:0] MOT_RL = 2'd3;

  // Fixed levels and thresholds
  localparam logic [11:0] ENGAGE_THR = 12'd1200;
  localparam logic [7:0]  IDLE_LEVEL = 8'd12;
  localparam logic [7:0]  LEVEL_MAX  = 8'd250;
  localparam logic [8:0]  PULSE_BASE = 9'd250;

  // Configuration register addresses
  localparam logic REG_MIX_DIVISOR = 1'b0;
  localparam logic [15:0] MIX_DIVISOR_RST = 16'd4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       load;       // capture the accepted input beat
    logic       decode;     // mode update, or full tick handling
    logic       div_load;   // form the mix sum of one motor and seed the divider
    logic       div_step;   // one quotient bit
    logic       div_store;  // write the saturated quotient to the level
    logic       pulse;      // restart the pulse frame
    logic       emit;       // load the output register
    logic [1:0] motor;      // motor the divider works on
  } qmix_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_tick;      // captured beat is a timer tick
    logic mix_now;      // frame beat that mixes (flight, not forced idle)
    logic div_trivial;  // level known without division
    logic out_free;     // output register can take a result
  } qmix_sts_t;

endpackage

// File: src/qmix_ctrl.sv
// ============================================================================
// qmix_ctrl: sequencing controller of the quad mixer
// Walks a beat: decode, four divisions (flight), pulse setup (frame), output.
// ============================================================================
module qmix_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  qmix_pkg::qmix_sts_t sts,
  output qmix_pkg::qmix_cmd_t cmd
);
  import qmix_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_DLOAD  = 3'd2;
  localparam logic [2:0] S_DSTEP  = 3'd3;
  localparam logic [2:0] S_DSTORE = 3'd4;
  localparam logic [2:0] S_PULSE  = 3'd5;
  localparam logic [2:0] S_EMIT   = 3'd6;

  localparam logic [2:0] LAST_STEP = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic [1:0] motor_r, motor_nxt;
  logic [2:0] step_r, step_nxt;

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    motor_nxt = motor_r;
    step_nxt  = step_r;
    cmd       = '0;
    cmd.motor = motor_r;
    in_tready = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (sts.is_tick) begin
          state_nxt = S_EMIT;
        end else if (sts.mix_now) begin
          motor_nxt = MOT_FR;
          state_nxt = S_DLOAD;
        end else begin
          state_nxt = S_PULSE;
        end
      end
      S_DLOAD: begin
        cmd.div_load = 1'b1;
        if (sts.div_trivial) begin
          if (motor_r == MOT_RL) begin
            state_nxt = S_PULSE;
          end else begin
            motor_nxt = motor_r + 2'd1;
          end
        end else begin
          step_nxt  = '0;
          state_nxt = S_DSTEP;
        end
      end
      S_DSTEP: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + 3'd1;
        if (step_r == LAST_STEP) begin
          state_nxt = S_DSTORE;
        end
      end
      S_DSTORE: begin
        cmd.div_store = 1'b1;
        if (motor_r == MOT_RL) begin
          state_nxt = S_PULSE;
        end else begin
          motor_nxt = motor_r + 2'd1;
          state_nxt = S_DLOAD;
        end
      end
      S_PULSE: begin
        cmd.pulse = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      motor_r <= '0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      motor_r <= motor_nxt;
      step_r  <= step_nxt;
    end
  end

endmodule

// File: src/qmix_dp.sv
// ============================================================================
// qmix_dp: datapath of the quad mixer
// Input capture, flight mode, shared bit-serial divider for the four mixes,
// pulse frame timing and the output register.
// ============================================================================
module qmix_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  qmix_pkg::qmix_cmd_t cmd,
  output qmix_pkg::qmix_sts_t sts,
  input  logic [15:0]         divisor,
  input  logic [qmix_pkg::InDataW-1:0]  in_tdata,   // throttle, roll, pitch, yaw, armed, force_idle
  input  logic                in_tuser,             // req_type
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [qmix_pkg::OutDataW-1:0] out_tdata,  // pulse_bits, FR, FL, RR, RL, flying
  output logic                out_tlast             // frame_done
);
  import qmix_pkg::*;

  // Captured input beat
  logic               req_r;
  logic [11:0]        thr_r;
  logic signed [15:0] roll_r, pitch_r, yaw_r;
  logic               armed_r, fidle_r;

  // Block state
  logic       in_flight_r;
  logic [7:0] lvl_r   [4];
  logic [7:0] start_r [4];
  logic [8:0] end_r, tick_r;
  logic [3:0] pulse_r;
  logic       active_r, done_r;

  // Divider registers; the partial remainder stays below the divisor in a division.
  logic [15:0] rem_r;
  logic [7:0]  nlow_r, quo_r;

  // Output register
  logic                out_valid_r, out_last_r;
  logic [OutDataW-1:0] out_data_r;

  // Lines whose start time has been reached, in output bit order
  function automatic logic [3:0] lines_due(input logic [7:0] st0, input logic [7:0] st1,
                                           input logic [7:0] st2, input logic [7:0] st3,
                                           input logic [8:0] tk);
    logic [3:0] hit;
    hit[0] = ({1'b0, st0} <= tk);
    hit[1] = ({1'b0, st1} <= tk);
    hit[2] = ({1'b0, st2} <= tk);
    hit[3] = ({1'b0, st3} <= tk);
    // bit0 FR, bit1 RL, bit2 FL, bit3 RR
    return {hit[MOT_RR], hit[MOT_FL], hit[MOT_RL], hit[MOT_FR]};
  endfunction

  // X-quad mix sum of the selected motor
  logic signed [17:0] thr_s, roll_s, pitch_s, yaw_s, sum;
  always_comb begin
    thr_s   = $signed({6'b0, thr_r});
    roll_s  = {{2{roll_r[15]}}, roll_r};
    pitch_s = {{2{pitch_r[15]}}, pitch_r};
    yaw_s   = {{2{yaw_r[15]}}, yaw_r};
    case (cmd.motor)
      MOT_FR:  sum = thr_s - roll_s + pitch_s - yaw_s;
      MOT_FL:  sum = thr_s + roll_s + pitch_s + yaw_s;
      MOT_RR:  sum = thr_s - roll_s - pitch_s + yaw_s;
      MOT_RL:  sum = thr_s + roll_s - pitch_s - yaw_s;
      default: sum = '0;
    endcase
  end

  // Divider seeding: a quotient of 256 or more saturates, so only eight
  // quotient bits are ever iterated.
  logic        sum_pos, sat;
  logic [16:0] num;
  always_comb begin
    sum_pos = !sum[17] && (sum != '0);
    num     = sum[16:0];
    sat     = ({7'b0, num} >= {divisor, 8'b0});
  end

  // One restoring division step
  logic [16:0] trial, diff;
  logic        fits;
  always_comb begin
    trial = {rem_r, nlow_r[7]};
    fits  = (trial >= {1'b0, divisor});
    diff  = trial - {1'b0, divisor};
  end

  // Pulse frame setup values
  logic [7:0] mx, mx01, mx23;
  logic [7:0] st_new [4];
  always_comb begin
    mx01 = (lvl_r[0] > lvl_r[1]) ? lvl_r[0] : lvl_r[1];
    mx23 = (lvl_r[2] > lvl_r[3]) ? lvl_r[2] : lvl_r[3];
    mx   = (mx01 > mx23) ? mx01 : mx23;
    for (int i = 0; i < 4; i++) begin
      st_new[i] = mx - lvl_r[i];
    end
  end

  logic [8:0] tick_inc;
  assign tick_inc = tick_r + 9'd1;

  // Status toward the controller
  always_comb begin
    sts.is_tick     = (req_r == REQ_TICK);
    sts.mix_now     = (req_r == REQ_FRAME) && in_flight_r && !fidle_r;
    sts.div_trivial = !sum_pos || sat;
    sts.out_free    = !out_valid_r || out_tready;
  end

  // Input capture and divider payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r   <= in_tuser;
      thr_r   <= in_tdata[11:0];
      roll_r  <= in_tdata[27:12];
      pitch_r <= in_tdata[43:28];
      yaw_r   <= in_tdata[59:44];
      armed_r <= in_tdata[60];
      fidle_r <= in_tdata[61];
    end
    if (cmd.div_load) begin
      rem_r  <= {7'b0, num[16:8]};
      nlow_r <= num[7:0];
      quo_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r  <= fits ? diff[15:0] : trial[15:0];
      nlow_r <= {nlow_r[6:0], 1'b0};
      quo_r  <= {quo_r[6:0], fits};
    end
  end

  // Mode, levels and pulse frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_flight_r <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        lvl_r[i]   <= '0;
        start_r[i] <= '0;
      end
      end_r    <= '0;
      tick_r   <= '0;
      pulse_r  <= '0;
      active_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      if (cmd.load) begin
        done_r <= 1'b0;
      end
      // Frame mode update, or a whole timer tick
      if (cmd.decode) begin
        if (req_r == REQ_FRAME) begin
          if (!(in_flight_r && !fidle_r)) begin
            if (thr_r >= ENGAGE_THR) begin
              in_flight_r <= 1'b1;
            end else begin
              in_flight_r <= 1'b0;
              for (int i = 0; i < 4; i++) begin
                lvl_r[i] <= IDLE_LEVEL;
              end
            end
          end
        end else if (active_r) begin
          tick_r <= tick_inc;
          if (tick_inc == end_r) begin
            pulse_r  <= '0;
            active_r <= 1'b0;
            done_r   <= 1'b1;
          end else begin
            pulse_r <= pulse_r | lines_due(start_r[0], start_r[1], start_r[2], start_r[3],
                                           tick_inc);
          end
        end
      end
      // Levels known without division: non-positive sum or saturation
      if (cmd.div_load && (!sum_pos || sat)) begin
        lvl_r[cmd.motor] <= sum_pos ? LEVEL_MAX : 8'd0;
      end
      if (cmd.div_store) begin
        lvl_r[cmd.motor] <= (quo_r > LEVEL_MAX) ? LEVEL_MAX : quo_r;
      end
      // Cancel any running pulse frame and start a new one when armed
      if (cmd.pulse) begin
        tick_r <= '0;
        if (armed_r) begin
          for (int i = 0; i < 4; i++) begin
            start_r[i] <= st_new[i];
          end
          end_r    <= {1'b0, mx} + PULSE_BASE;
          active_r <= 1'b1;
          pulse_r  <= lines_due(st_new[0], st_new[1], st_new[2], st_new[3], 9'd0);
        end else begin
          active_r <= 1'b0;
          pulse_r  <= '0;
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= {3'b0, in_flight_r, lvl_r[MOT_RL], lvl_r[MOT_RR], lvl_r[MOT_FL],
                     lvl_r[MOT_FR], pulse_r};
      out_last_r <= done_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

// File: src/quad_mixer_esc_pulse_generator.sv
// ============================================================================
// quad_mixer_esc_pulse_generator: X-quad motor mixer with ESC pulse timing
// Control frames update flight mode and the four motor levels and restart
// the pulse frame, or only cancel it when unarmed; timer ticks step the
// four pulse lines.
//   channel  | direction | beat contents
//   ---------+-----------+----------------------------------------------------
//   in_      | slave     | tuser req_type; tdata throttle, drives, flags
//   out_     | master    | tdata pulse_bits, four levels, flying; tlast done
//   APB      | slave     | mix_divisor at byte address 0
//
// A tick goes from accept through decode to output; an idle-mode frame adds
// the pulse setup. A flight frame runs one shared restoring divider over the
// four motors: load, quotient steps, store (load alone if saturated or zero).
// The output register lets a finished result wait while the next beat is
// taken; a stalled output holds the controller only in its last step.
// Reset is synchronous and clears mode, levels and pulse state at once.
// ============================================================================
module quad_mixer_esc_pulse_generator (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // throttle[11:0], roll[27:12], pitch[43:28],
                                  // yaw[59:44], armed[60], force_idle[61]
  input  logic        in_tuser,   // req_type
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // pulse_bits[3:0], front_right[11:4],
                                  // front_left[19:12], rear_right[27:20],
                                  // rear_left[35:28], flying[36]
  output logic        out_tlast,  // frame_done
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import qmix_pkg::*;

  logic [15:0] mix_div_r;
  logic [15:0] div_eff;
  qmix_cmd_t   cmd;
  qmix_sts_t   sts;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mix_div_r <= MIX_DIVISOR_RST;
    end else if (psel && penable && pwrite && pready && (paddr == REG_MIX_DIVISOR)) begin
      mix_div_r <= pwdata[15:0];
    end
  end

  assign prdata  = (paddr == REG_MIX_DIVISOR) ? {16'b0, mix_div_r} : '0;

  // A divisor of zero acts as one
  assign div_eff = (mix_div_r == '0) ? 16'd1 : mix_div_r;

  qmix_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  qmix_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .divisor    (div_eff),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // Saturation keeps every level within range.
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[11:4] <= LEVEL_MAX) && (out_tdata[19:12] <= LEVEL_MAX) &&
                   (out_tdata[27:20] <= LEVEL_MAX) && (out_tdata[35:28] <= LEVEL_MAX))
    else $error("motor level above maximum");

  // The beat that ends a pulse frame carries all lines low.
  a_done_lines_low: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata[3:0] == 4'h0))
    else $error("pulse line high on frame end");

  // Outside flight the four levels are always the same value.
  a_idle_levels_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[36]) |-> (out_tdata[11:4] == out_tdata[19:12]) &&
      (out_tdata[19:12] == out_tdata[27:20]) && (out_tdata[27:20] == out_tdata[35:28]))
    else $error("unequal levels in idle mode");

  // A divisor write lands in the register.
  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && (paddr == REG_MIX_DIVISOR)) |=>
      (mix_div_r == $past(pwdata[15:0])))
    else $error("divisor write lost");

endmodule

// File: tb/sv/testbench.sv
// ============================================================================
// testbench: self-checking bench for the quad mixer and ESC pulse generator
// Streams control frames and timer ticks into the block, predicts each result
// beat with a behavioral copy of the mixer and pulse timer, and compares every
// output beat field by field. The mix divisor is changed between phases.
// ============================================================================
module testbench;
  import qmix_pkg::*;

  // One input beat: request kind plus the frame fields.
  typedef struct packed {
    logic               req;
    logic [11:0]        thr;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    logic signed [15:0] yaw;
    logic               armed;
    logic               force_idle;
  } ctl_beat_t;

  // One result beat, levels indexed by the package motor order.
  typedef struct packed {
    logic [3:0]      lines;
    logic [3:0][7:0] level;
    logic            flying;
    logic            done;
  } motor_status_t;

  // Pulse line driven by each motor, in motor index order FR, FL, RR, RL.
  localparam logic [3:0] LINE_OF_MOTOR [4] = '{4'b0001, 4'b0100, 4'b1000, 4'b0010};
  localparam int LONG_TICK_RUN = 264;
  localparam int PHASE_ITEMS   = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // throttle[11:0], roll[27:12], pitch[43:28],
                                // yaw[59:44], armed[60], force_idle[61]
  logic        in_tuser = 1'b0; // req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // pulse_bits[3:0], front_right[11:4],
                                // front_left[19:12], rear_right[27:20],
                                // rear_left[35:28], flying[36]
  logic        out_tlast;       // frame_done
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic        paddr = REG_MIX_DIVISOR;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Predicted state of the mixer and pulse timer.
  logic [15:0]     divisor_q = MIX_DIVISOR_RST;
  logic            flying_q = 1'b0;
  logic [3:0][7:0] level_q = '0;
  logic [3:0][7:0] start_q = '0;
  logic [8:0]      end_q = '0;
  logic [8:0]      ticks_q = '0;
  logic [3:0]      lines_q = '0;
  logic            running_q = 1'b0;

  ctl_beat_t     pending_beats[$];
  motor_status_t motor_status_due[$];
  ctl_beat_t     beat_on_bus;
  int            items_queued = 0;
  int            results_checked = 0;
  int            fail_count = 0;
  int            send_gap = 0;
  int            stall_left = 0;
  int            in_calm = 0;
  int            out_calm = 0;

  quad_mixer_esc_pulse_generator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  function automatic void check_field(string field, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      fail_count++;
    end
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch.
  function automatic int draw_pause(ref int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Scale one mixed sum to a motor level: truncating divide, clamp to 0..250.
  function automatic logic [7:0] to_level(int sum);
    int d;
    int q;
    d = (divisor_q == 16'd0) ? 1 : int'(divisor_q);
    q = sum / d;
    if (q < 0) q = 0;
    if (q > int'(LEVEL_MAX)) q = int'(LEVEL_MAX);
    return q[7:0];
  endfunction

  // Raise every line whose start time has been reached.
  function automatic void raise_lines();
    for (int i = 0; i < 4; i++)
      if ({1'b0, start_q[i]} <= ticks_q) lines_q |= LINE_OF_MOTOR[i];
  endfunction

  // Update the predicted state for one accepted beat and queue its result.
  function automatic void advance_mixer(ctl_beat_t b);
    int thr;
    int r;
    int p;
    int y;
    logic [7:0] peak;
    logic done;
    done = 1'b0;
    if (b.req == REQ_FRAME) begin
      thr = int'(b.thr);
      r = int'($signed(b.roll));
      p = int'($signed(b.pitch));
      y = int'($signed(b.yaw));
      if (b.force_idle) flying_q = 1'b0;
      if (!flying_q) begin
        if (b.thr >= ENGAGE_THR) flying_q = 1'b1;
        else for (int i = 0; i < 4; i++) level_q[i] = IDLE_LEVEL;
      end else begin
        level_q[MOT_FR] = to_level(thr - r + p - y);
        level_q[MOT_FL] = to_level(thr + r + p + y);
        level_q[MOT_RR] = to_level(thr - r - p + y);
        level_q[MOT_RL] = to_level(thr + r - p - y);
      end
      // A frame always cancels the running pulse frame.
      lines_q = '0;
      running_q = 1'b0;
      ticks_q = '0;
      if (b.armed) begin
        peak = '0;
        for (int i = 0; i < 4; i++)
          if (level_q[i] > peak) peak = level_q[i];
        for (int i = 0; i < 4; i++) start_q[i] = peak - level_q[i];
        end_q = {1'b0, peak} + PULSE_BASE;
        running_q = 1'b1;
        raise_lines();
      end
    end else if (running_q) begin
      ticks_q = ticks_q + 9'd1;
      if (ticks_q == end_q) begin
        lines_q = '0;
        running_q = 1'b0;
        done = 1'b1;
      end else begin
        raise_lines();
      end
    end
    motor_status_due.push_back('{lines: lines_q, level: level_q, flying: flying_q, done: done});
  endfunction

  function automatic ctl_beat_t make_beat(logic req, logic [11:0] thr, logic [15:0] roll,
                                          logic [15:0] pitch, logic [15:0] yaw,
                                          logic armed, logic force_idle);
    return '{req: req, thr: thr, roll: roll, pitch: pitch, yaw: yaw,
             armed: armed, force_idle: force_idle};
  endfunction

  function automatic void queue_beat(ctl_beat_t b);
    pending_beats.push_back(b);
    items_queued++;
  endfunction

  // A tick carries random don't-care content in the frame fields.
  function automatic void queue_tick();
    queue_beat(make_beat(REQ_TICK, 12'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 1'($urandom), 1'($urandom)));
  endfunction

  // Drive values: mostly moderate so levels spread, sometimes full range.
  function automatic logic [15:0] rand_drive();
    int v;
    if ($urandom_range(0, 99) < 80) begin
      v = $urandom_range(0, 800);
      v = v - 400;
      return v[15:0];
    end
    return 16'($urandom);
  endfunction

  // One frame followed by a run of ticks.
  function automatic void queue_episode(int tick_total);
    int r;
    logic [11:0] thr;
    r = $urandom_range(0, 99);
    if (r < 30) thr = 12'($urandom_range(0, 1199));
    else if (r < 90) thr = 12'($urandom_range(1200, 4095));
    else thr = 12'($urandom);
    queue_beat(make_beat(REQ_FRAME, thr, rand_drive(), rand_drive(), rand_drive(),
                         $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 10));
    repeat (tick_total) queue_tick();
  endfunction

  function automatic int short_tick_run();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
  endfunction

  // Write the divisor, then read it back.
  task automatic write_divisor(input logic [15:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= REG_MIX_DIVISOR;
    pwdata <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    divisor_q = value;
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    check_field("mix_divisor", {16'h0000, value}, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    while (results_checked < items_queued) @(posedge clk);
  endtask

  // Input driver: presents queued beats with random gaps between them.
  always @(posedge clk) begin : beat_driver
    if (rst_n && (!in_tvalid || in_tready)) begin
      if (in_tvalid) advance_mixer(beat_on_bus);
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        beat_on_bus = pending_beats.pop_front();
        in_tdata <= {2'b00, beat_on_bus.force_idle, beat_on_bus.armed, beat_on_bus.yaw,
                     beat_on_bus.pitch, beat_on_bus.roll, beat_on_bus.thr};
        in_tuser <= beat_on_bus.req;
        in_tvalid <= 1'b1;
        send_gap = draw_pause(in_calm);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Output monitor: checks each result beat and stalls the output at random.
  always @(posedge clk) begin : result_monitor
    motor_status_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (motor_status_due.size() == 0) begin
          $error("result beat with no prediction pending");
          fail_count++;
        end else begin
          want = motor_status_due.pop_front();
          check_field("pulse_bits", want.lines, out_tdata[3:0]);
          check_field("level_front_right", want.level[MOT_FR], out_tdata[11:4]);
          check_field("level_front_left", want.level[MOT_FL], out_tdata[19:12]);
          check_field("level_rear_right", want.level[MOT_RR], out_tdata[27:20]);
          check_field("level_rear_left", want.level[MOT_RL], out_tdata[35:28]);
          check_field("flying", want.flying, out_tdata[36]);
          check_field("frame_done", want.done, out_tlast);
        end
        results_checked++;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        stall_left = draw_pause(out_calm);
        out_tready <= (stall_left == 0);
      end
    end
  end

  // Stimulus sequence.
  initial begin : stimulus
    int target;
    logic [15:0] settings [5];
    settings = '{16'd1, 16'd65535, 16'd0, 16'($urandom_range(2, 12)),
                 16'($urandom_range(2, 12))};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset divisor.
    queue_tick();                                                  // tick with no frame
    queue_beat(make_beat(REQ_FRAME, 12'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0));
    queue_tick();
    queue_beat(make_beat(REQ_FRAME, 12'd1199, 16'd5, 16'd5, 16'd5, 1'b0, 1'b0));
    queue_tick();                                                  // unarmed: nothing runs
    queue_beat(make_beat(REQ_FRAME, 12'd1200, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0));
    queue_beat(make_beat(REQ_FRAME, 12'd4095, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0));
    queue_beat(make_beat(REQ_FRAME, 12'd1000, 16'h7fff, 16'h8000, 16'h7fff, 1'b1, 1'b0));
    queue_beat(make_beat(REQ_FRAME, 12'd800, 16'd100, -16'sd40, 16'd20, 1'b1, 1'b0));
    repeat (4) queue_tick();
    queue_beat(make_beat(REQ_FRAME, 12'd4095, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1));
    queue_beat(make_beat(REQ_FRAME, 12'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1));
    queue_beat(make_beat(REQ_FRAME, 12'd2000, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0));
    queue_beat(make_beat(REQ_FRAME, 12'd0, 16'h8000, 16'h7fff, 16'h8000, 1'b1, 1'b0));
    queue_beat(make_beat(REQ_FRAME, 12'd4095, 16'hffff, 16'hffff, 16'hffff, 1'b1, 1'b0));
    queue_beat(make_beat(REQ_FRAME, 12'd3000, -16'sd2000, 16'd1500, -16'sd700, 1'b1, 1'b0));
    repeat (3) queue_tick();

    // Idle levels give a pulse frame that ends at tick 262; run past its end.
    queue_beat(make_beat(REQ_FRAME, 12'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1));
    repeat (LONG_TICK_RUN) queue_tick();

    // Random part at the reset divisor.
    target = items_queued + PHASE_ITEMS;
    while (items_queued < target) queue_episode(short_tick_run());
    wait_drained();

    // Further divisor settings, each followed by random frames and ticks.
    for (int s = 0; s < 5; s++) begin
      write_divisor(settings[s]);
      target = items_queued + PHASE_ITEMS;
      while (items_queued < target) queue_episode(short_tick_run());
      wait_drained();
    end

    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS quad_mixer_esc_pulse_generator");
    end else begin
      $display("FAIL quad_mixer_esc_pulse_generator");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #20_000_000;
    $display("FAIL quad_mixer_esc_pulse_generator");
    $finish;
  end

endmodule
